FILE: src/thup_pkg.sv
package thup_pkg;

	localparam int IN_SIDE  = 8;
	localparam int OUT_SIDE = 13;
	localparam int MAX_RES  = 4;

	localparam int IDX_W   = $clog2(IN_SIDE);
	localparam int COORD_W = $clog2(OUT_SIDE);
	localparam int CNT_W   = $clog2(OUT_SIDE + 1);
	localparam int K_W     = $clog2(MAX_RES);

	localparam int TEMP_W  = 12;
	localparam int PROB_W  = 16;
	localparam int FIELD_W = 4;

	localparam int S_DATA_W = 16;
	localparam int M_DATA_W = 48;

	localparam logic signed [TEMP_W-1:0] THRESH_RST = 12'sd128;
	localparam logic [PROB_W-1:0] PROB_ONE = 16'd32768;

	localparam logic [PROB_W-1:0] PROB_TABLE [16] = '{
		16'd32768, 16'd30783, 16'd25520, 16'd18671, 16'd12055, 16'd6869, 16'd3454, 16'd1533,
		16'd600,   16'd207,   16'd63,    16'd17,    16'd4,     16'd1,    16'd0,    16'd0
	};

	localparam logic RESULT_CELL    = 1'b0;
	localparam logic RESULT_SUMMARY = 1'b1;

	// number of output cells that map back to input index i
	function automatic logic [CNT_W-1:0] cell_count(input logic [IDX_W-1:0] i);
		int n;
		n = 0;
		for (int c = 0; c < OUT_SIDE; c++) begin
			if ((c * (IN_SIDE - 1)) / (OUT_SIDE - 1) == int'(i))
				n++;
		end
		return CNT_W'(n);
	endfunction

	// lowest output cell that maps back to input index i
	function automatic logic [COORD_W-1:0] cell_first(input logic [IDX_W-1:0] i);
		int f;
		f = 0;
		for (int c = OUT_SIDE - 1; c >= 0; c--) begin
			if ((c * (IN_SIDE - 1)) / (OUT_SIDE - 1) == int'(i))
				f = c;
		end
		return COORD_W'(f);
	endfunction

	typedef struct packed {
		logic [FIELD_W-1:0]            cell_x;
		logic [FIELD_W-1:0]            cell_y;
		logic signed [TEMP_W-1:0]      value;
		logic [FIELD_W-1:0]            hot_x;
		logic [FIELD_W-1:0]            hot_y;
		logic [PROB_W-1:0]             prob;
	} result_t;

endpackage

FILE: src/thermal_hotspot_upscaler_unit.sv
// Channel  Dir  Handshake          Payload
// s_       in   s_tvalid/s_tready  tdata: temperature; tuser: first_of_frame
// m_       out  m_tvalid/m_tready  tdata: cell/summary fields; tuser: kind; tlast
// cfg_     in   cfg_wr_en          cfg_wr_data: alarm threshold
//
// Each pixel yields 1 to 4 results at one per cycle from the result register unless m_tready
// stalls it (2 on the frame's last pixel: one cell and the summary). The next pixel is taken
// in the cycle its predecessor's final result is loaded.
// Reset clears frame position, running maximum, hotspot and sets the threshold to THRESH_RST (128).
// A stall on m_tready holds the result register and, in turn, the input side.
module thermal_hotspot_upscaler_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [11:0] temperature, zero fill above
	input  logic [0:0]  s_tuser,   // [0] first_of_frame
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // [3:0] cell_x, [7:4] cell_y, [19:8] value, [23:20] hot_x,
	                               // [27:24] hot_y, [43:28] fire_probability, zero fill above
	output logic [0:0]  m_tuser,   // [0] result_kind
	output logic        m_tlast,
	input  logic        cfg_wr_en,
	input  logic [11:0] cfg_wr_data
);

	// frame state
	logic [thup_pkg::IDX_W-1:0]         col_q, row_q;
	logic signed [thup_pkg::TEMP_W-1:0] rmax_q;
	logic [thup_pkg::FIELD_W-1:0]       hot_x_q, hot_y_q;
	logic signed [thup_pkg::TEMP_W-1:0] thr_q;

	// item under emission
	logic                               busy_q, cells_q, lastpix_q;
	logic signed [thup_pkg::TEMP_W-1:0] t_q, smax_q;
	logic [thup_pkg::COORD_W-1:0]       x0_q, y0_q;
	logic [thup_pkg::CNT_W-1:0]         nx_q, ny_q, a_q, b_q;
	logic [thup_pkg::K_W-1:0]           k_q;
	logic [thup_pkg::FIELD_W-1:0]       shx_q, shy_q;

	// accept-side logic
	logic                               acc, first;
	logic [thup_pkg::IDX_W-1:0]         col, row;
	logic signed [thup_pkg::TEMP_W-1:0] base, temp, newmax;
	logic [thup_pkg::CNT_W-1:0]         nx, ny;
	logic                               has_cells, upd, lastpix;

	assign first  = s_tuser[0];
	assign temp   = signed'(s_tdata[thup_pkg::TEMP_W-1:0]);
	assign col    = first ? '0 : col_q;
	assign row    = first ? '0 : row_q;
	assign base   = first ? '0 : rmax_q;
	assign nx     = thup_pkg::cell_count(col);
	assign ny     = thup_pkg::cell_count(row);
	assign has_cells = (nx != '0) && (ny != '0);
	assign upd    = has_cells && (temp > base);
	assign newmax = upd ? temp : base;
	assign lastpix = (col == thup_pkg::IDX_W'(thup_pkg::IN_SIDE - 1)) &&
	                 (row == thup_pkg::IDX_W'(thup_pkg::IN_SIDE - 1));

	// emission logic
	logic                              out_load, emit, cell_end, cur_last, a_end;
	logic [thup_pkg::K_W-1:0]          k_cap;
	logic [thup_pkg::COORD_W-1:0]      cx, cy;
	logic signed [thup_pkg::TEMP_W:0]  thr_gap;
	logic [thup_pkg::PROB_W-1:0]       prob;
	thup_pkg::result_t                 res;

	assign out_load = !m_tvalid || m_tready;
	assign emit     = busy_q && out_load;
	assign k_cap    = lastpix_q ? thup_pkg::K_W'(thup_pkg::MAX_RES - 2)
	                            : thup_pkg::K_W'(thup_pkg::MAX_RES - 1);
	assign a_end    = (a_q == nx_q - thup_pkg::CNT_W'(1));
	assign cell_end = (a_end && (b_q == ny_q - thup_pkg::CNT_W'(1))) || (k_q == k_cap);
	assign cur_last = cells_q ? (cell_end && !lastpix_q) : 1'b1;
	assign s_tready = !busy_q || (out_load && cur_last);
	assign acc      = s_tvalid && s_tready;

	assign cx = x0_q + thup_pkg::COORD_W'(a_q);
	assign cy = y0_q + thup_pkg::COORD_W'(b_q);

	assign thr_gap = {thr_q[thup_pkg::TEMP_W-1], thr_q} - {smax_q[thup_pkg::TEMP_W-1], smax_q};

	always_comb begin
		if (thr_gap[thup_pkg::TEMP_W])
			prob = thup_pkg::PROB_ONE;
		else if (thr_gap > 13'sd15)
			prob = '0;
		else
			prob = thup_pkg::PROB_TABLE[thr_gap[3:0]];
	end

	always_comb begin
		if (cells_q) begin
			res.cell_x = thup_pkg::FIELD_W'(cx);
			res.cell_y = thup_pkg::FIELD_W'(cy);
			res.value  = t_q;
			res.hot_x  = '0;
			res.hot_y  = '0;
			res.prob   = '0;
		end else begin
			res.cell_x = '0;
			res.cell_y = '0;
			res.value  = smax_q;
			res.hot_x  = shx_q;
			res.hot_y  = shy_q;
			res.prob   = prob;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= thup_pkg::THRESH_RST;
		end else if (cfg_wr_en) begin
			thr_q <= signed'(cfg_wr_data);
		end
	end

	// frame state advances on each input transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			rmax_q  <= '0;
			hot_x_q <= '0;
			hot_y_q <= '0;
		end else if (acc) begin
			if (upd) begin
				hot_x_q <= thup_pkg::FIELD_W'(thup_pkg::cell_first(col));
				hot_y_q <= thup_pkg::FIELD_W'(thup_pkg::cell_first(row));
			end
			if (lastpix) begin
				col_q  <= '0;
				row_q  <= '0;
				rmax_q <= '0;
			end else begin
				rmax_q <= newmax;
				if (col == thup_pkg::IDX_W'(thup_pkg::IN_SIDE - 1)) begin
					col_q <= '0;
					row_q <= row + thup_pkg::IDX_W'(1);
				end else begin
					col_q <= col + thup_pkg::IDX_W'(1);
					row_q <= row;
				end
			end
		end
	end

	// item control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			cells_q   <= 1'b0;
			lastpix_q <= 1'b0;
			a_q       <= '0;
			b_q       <= '0;
			k_q       <= '0;
		end else if (acc) begin
			busy_q    <= has_cells || lastpix;
			cells_q   <= has_cells;
			lastpix_q <= lastpix;
			a_q       <= '0;
			b_q       <= '0;
			k_q       <= '0;
		end else if (emit) begin
			if (cells_q) begin
				if (cell_end) begin
					cells_q <= 1'b0;
					busy_q  <= lastpix_q;
				end else begin
					k_q <= k_q + thup_pkg::K_W'(1);
					if (a_end) begin
						a_q <= '0;
						b_q <= b_q + thup_pkg::CNT_W'(1);
					end else begin
						a_q <= a_q + thup_pkg::CNT_W'(1);
					end
				end
			end else begin
				busy_q <= 1'b0;
			end
		end
	end

	// item payload
	always_ff @(posedge clk) begin
		if (acc) begin
			t_q    <= temp;
			smax_q <= newmax;
			x0_q   <= thup_pkg::cell_first(col);
			y0_q   <= thup_pkg::cell_first(row);
			nx_q   <= nx;
			ny_q   <= ny;
			shx_q  <= upd ? thup_pkg::FIELD_W'(thup_pkg::cell_first(col)) : hot_x_q;
			shy_q  <= upd ? thup_pkg::FIELD_W'(thup_pkg::cell_first(row)) : hot_y_q;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (out_load) begin
			m_tvalid <= busy_q;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			m_tdata  <= {4'b0, res.prob, res.hot_y, res.hot_x, res.value, res.cell_y, res.cell_x};
			m_tuser  <= cells_q ? thup_pkg::RESULT_CELL : thup_pkg::RESULT_SUMMARY;
			m_tlast  <= cur_last;
		end
	end

endmodule

FILE: src/thup_checker.sv
module thup_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [15:0] s_tdata,
	input logic [0:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [47:0] m_tdata,
	input logic [0:0]  m_tuser,
	input logic        m_tlast,
	input logic        cfg_wr_en,
	input logic [11:0] cfg_wr_data
);

	// hold a stalled result
	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result dropped or changed under stall");

	// summary closes the pixel's results
	a_summary_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser[0] == thup_pkg::RESULT_SUMMARY) |-> m_tlast)
		else $error("summary without tlast");

	// cell results carry no hotspot or probability
	a_cell_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser[0] == thup_pkg::RESULT_CELL) |-> (m_tdata[47:20] == '0))
		else $error("cell result carries summary fields");

	// summary has zero cell coordinates and probability at most 1.0
	a_summary_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser[0] == thup_pkg::RESULT_SUMMARY) |->
			(m_tdata[7:0] == '0) && (m_tdata[43:28] <= thup_pkg::PROB_ONE))
		else $error("summary fields out of range");

	// a transfer that did not end the pixel is followed by another result
	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=> m_tvalid)
		else $error("gap inside a pixel's results");

endmodule

bind thermal_hotspot_upscaler_unit thup_checker u_thup_checker (.*);
